/* src/rlu_pkg.sv */
package rlu_pkg;

  localparam int unsigned VOLT_W      = 12;
  localparam int unsigned DELAY_W     = 12;
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TWO = 3'd5;

  localparam logic [CFG_W-1:0] RST_HIGH_ONE  = 12'd270;
  localparam logic [CFG_W-1:0] RST_LOW_ONE   = 12'd170;
  localparam logic [CFG_W-1:0] RST_HIGH_TWO  = 12'd250;
  localparam logic [CFG_W-1:0] RST_LOW_TWO   = 12'd190;
  localparam logic [CFG_W-1:0] RST_DELAY_ONE = 12'd1;
  localparam logic [CFG_W-1:0] RST_DELAY_TWO = 12'd10;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_EV1    = 3'd1,
    MODE_EV2    = 3'd2,
    MODE_ALARM  = 3'd3,
    MODE_WAIT   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TRIP    = 2'd1,
    EV_RESTORE = 2'd2
  } event_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

  typedef struct packed {
    logic [VOLT_W-1:0]  high_one;
    logic [VOLT_W-1:0]  low_one;
    logic [VOLT_W-1:0]  high_two;
    logic [VOLT_W-1:0]  low_two;
    logic [DELAY_W-1:0] delay_one;
    logic [DELAY_W-1:0] delay_two;
  } cfg_t;

  typedef struct packed {
    event_e alarm_event;
    mode_e  mode;
    logic   relay_on;
  } result_t;

endpackage

/* src/two_stage_voltage_protection_relay_unit.sv */
// A request accepted into the input register is evaluated into the result register,
// from which the sink takes its result.
// One request per cycle unless the sink stalls; the mode and elapsed counter update in the
// same cycle as the comparisons, so the next request sees them at once.
// Reset clears both handshake stages, returns the mode to normal with the relay
// on, zeroes the elapsed counter and loads the default thresholds and delays.
module two_stage_voltage_protection_relay_unit #(
  parameter int unsigned ELAPSED_WIDTH = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [11:0] voltage, [15:12] zero
  input  logic [rlu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] relay_on, [3:1] mode, [5:4] alarm_event, [7:6] zero
  output logic [rlu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [rlu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rlu_pkg::CFG_W-1:0]          cfg_data_i
);

  rlu_pkg::cfg_t                cfg;
  logic                         in_vld_q;
  logic                         in_type_q;
  logic [rlu_pkg::VOLT_W-1:0]   in_volt_q;
  logic                         out_vld_q;
  rlu_pkg::result_t             out_res_q;
  rlu_pkg::mode_e               mode_q;
  rlu_pkg::mode_e               mode_d;
  logic [ELAPSED_WIDTH-1:0]     elapsed_q;
  logic [ELAPSED_WIDTH-1:0]     elapsed_d;
  rlu_pkg::result_t             res_d;
  logic                         advance;
  logic                         fire;

  rlu_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rlu_eval #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_eval (
    .cfg_i      (cfg),
    .mode_i     (mode_q),
    .elapsed_i  (elapsed_q),
    .req_type_i (in_type_q),
    .voltage_i  (in_volt_q),
    .mode_o     (mode_d),
    .elapsed_o  (elapsed_d),
    .result_o   (res_d)
  );

  // The result register is free when empty or being drained this cycle.
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= rlu_pkg::MODE_NORMAL;
      elapsed_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        mode_q    <= mode_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_type_q <= s_axis_tuser;
      in_volt_q <= s_axis_tdata[rlu_pkg::VOLT_W-1:0];
    end
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_res_q.alarm_event, out_res_q.mode, out_res_q.relay_on};

endmodule

/* src/rlu_regs.sv */
module rlu_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlu_pkg::CFG_W-1:0]       cfg_data_i,
  output rlu_pkg::cfg_t                   cfg_o
);

  rlu_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_one  <= rlu_pkg::RST_HIGH_ONE;
      cfg_q.low_one   <= rlu_pkg::RST_LOW_ONE;
      cfg_q.high_two  <= rlu_pkg::RST_HIGH_TWO;
      cfg_q.low_two   <= rlu_pkg::RST_LOW_TWO;
      cfg_q.delay_one <= rlu_pkg::RST_DELAY_ONE;
      cfg_q.delay_two <= rlu_pkg::RST_DELAY_TWO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rlu_pkg::REG_HIGH_ONE:  cfg_q.high_one  <= cfg_data_i;
        rlu_pkg::REG_LOW_ONE:   cfg_q.low_one   <= cfg_data_i;
        rlu_pkg::REG_HIGH_TWO:  cfg_q.high_two  <= cfg_data_i;
        rlu_pkg::REG_LOW_TWO:   cfg_q.low_two   <= cfg_data_i;
        rlu_pkg::REG_DELAY_ONE: cfg_q.delay_one <= cfg_data_i;
        rlu_pkg::REG_DELAY_TWO: cfg_q.delay_two <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/rlu_eval.sv */
module rlu_eval #(
  parameter int unsigned ELAPSED_WIDTH = 12
) (
  input  rlu_pkg::cfg_t                cfg_i,
  input  rlu_pkg::mode_e               mode_i,
  input  logic [ELAPSED_WIDTH-1:0]     elapsed_i,
  input  logic                         req_type_i,
  input  logic [rlu_pkg::VOLT_W-1:0]   voltage_i,
  output rlu_pkg::mode_e               mode_o,
  output logic [ELAPSED_WIDTH-1:0]     elapsed_o,
  output rlu_pkg::result_t             result_o
);

  localparam int unsigned CMP_W =
    (ELAPSED_WIDTH > rlu_pkg::DELAY_W) ? ELAPSED_WIDTH : rlu_pkg::DELAY_W;

  logic             hit_one;
  logic             hit_two;
  logic             inside_one;
  logic             pass_one;
  logic             pass_two;
  logic [CMP_W-1:0] elapsed_x;
  logic             trip;
  rlu_pkg::event_e  event_d;

  assign hit_one    = (voltage_i >= cfg_i.high_one) || (voltage_i <= cfg_i.low_one);
  assign hit_two    = (voltage_i >= cfg_i.high_two) || (voltage_i <= cfg_i.low_two);
  assign inside_one = (voltage_i < cfg_i.high_one) && (voltage_i > cfg_i.low_one);

  // A delay beyond the counter's reach never passes, so compare at the wider width.
  assign elapsed_x = CMP_W'(elapsed_i);
  assign pass_one  = elapsed_x >= CMP_W'(cfg_i.delay_one);
  assign pass_two  = elapsed_x >= CMP_W'(cfg_i.delay_two);

  always_comb begin
    mode_o    = mode_i;
    elapsed_o = elapsed_i;
    event_d   = rlu_pkg::EV_NONE;
    trip      = 1'b0;
    if (req_type_i == rlu_pkg::REQ_TICK) begin
      if (elapsed_i != {ELAPSED_WIDTH{1'b1}}) begin
        elapsed_o = elapsed_i + ELAPSED_WIDTH'(1);
      end
    end else begin
      case (mode_i)
        rlu_pkg::MODE_EV1, rlu_pkg::MODE_EV2: begin
          if (hit_two) begin
            mode_o = rlu_pkg::MODE_EV2;
            trip   = pass_two;
          end else if (hit_one) begin
            mode_o = rlu_pkg::MODE_EV1;
            trip   = pass_one;
          end else begin
            mode_o = rlu_pkg::MODE_NORMAL;
          end
        end
        rlu_pkg::MODE_ALARM: begin
          trip = 1'b1;
        end
        rlu_pkg::MODE_WAIT: begin
          if (inside_one) begin
            if (pass_two) begin
              mode_o  = rlu_pkg::MODE_NORMAL;
              event_d = rlu_pkg::EV_RESTORE;
            end
          end else begin
            elapsed_o = '0;
          end
        end
        default: begin
          // Normal mode, and any unused code treated as normal.
          if (hit_one) begin
            mode_o    = rlu_pkg::MODE_EV1;
            elapsed_o = '0;
          end else if (hit_two) begin
            mode_o    = rlu_pkg::MODE_EV2;
            elapsed_o = '0;
          end else begin
            mode_o = rlu_pkg::MODE_NORMAL;
          end
        end
      endcase
      if (trip) begin
        mode_o    = rlu_pkg::MODE_WAIT;
        elapsed_o = '0;
        event_d   = rlu_pkg::EV_TRIP;
      end
    end
  end

  assign result_o.alarm_event = event_d;
  assign result_o.mode        = mode_o;
  assign result_o.relay_on    = (mode_o < rlu_pkg::MODE_ALARM);

endmodule

/* src/rlu_checker.sv */
module rlu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rlu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       relay_on;
  logic [2:0] mode;
  logic [1:0] alarm_event;

  assign relay_on    = m_axis_tdata[0];
  assign mode        = m_axis_tdata[3:1];
  assign alarm_event = m_axis_tdata[5:4];

  // The relay is closed exactly while the mode is below alarm.
  a_relay_follows_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (relay_on == (mode < rlu_pkg::MODE_ALARM)))
    else $error("relay drive disagrees with mode");

  // A trip always lands in the waiting mode, a restore always in normal.
  a_event_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (alarm_event == rlu_pkg::EV_TRIP)) |-> (mode == rlu_pkg::MODE_WAIT))
    else $error("trip result not in waiting mode");

  a_restore_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (alarm_event == rlu_pkg::EV_RESTORE)) |->
      (mode == rlu_pkg::MODE_NORMAL))
    else $error("restore result not in normal mode");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind two_stage_voltage_protection_relay_unit rlu_checker u_rlu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/two_stage_voltage_protection_relay_unit_tb.sv */
`timescale 1ns / 1ps

module two_stage_voltage_protection_relay_unit_tb;

  localparam int unsigned ELAPSED_W      = 12;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          PHASE_ITEMS    = 160;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          LONG_TICKS     = 100;

  typedef logic [rlu_pkg::VOLT_W-1:0]    volt_t;
  typedef logic [rlu_pkg::CFG_W-1:0]     word_t;
  typedef logic [rlu_pkg::DELAY_W-1:0]   delay_t;
  typedef logic [rlu_pkg::CFG_IDX_W-1:0] idx_t;

  // Indexes past the register list; the block must ignore writes to them.
  localparam idx_t REG_SPARE_A = 3'd6;
  localparam idx_t REG_SPARE_B = 3'd7;

  typedef struct {
    bit                 is_cfg;
    rlu_pkg::req_e      req;
    word_t              val;
    idx_t               idx;
    bit                 typed;
    rlu_pkg::result_t   res;
  } step_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rlu_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rlu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  idx_t                            cfg_idx_i = '0;
  word_t                           cfg_data_i = '0;

  two_stage_voltage_protection_relay_unit #(
    .ELAPSED_WIDTH(ELAPSED_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Protection state as the block should hold it.
  rlu_pkg::cfg_t        relay_cfg;
  rlu_pkg::mode_e       prot_mode;
  logic [ELAPSED_W-1:0] secs_elapsed;

  rlu_pkg::result_t results_due[$];
  int      fail_count = 0;
  int      sent_count = 0;
  int      burst_left = 0;
  bit      no_idle = 1'b0;
  int      idle_cycles = 0;
  int      rx_cycle = 0;
  int      rx_style = 0;

  function automatic rlu_pkg::result_t relay_predict(rlu_pkg::req_e req, volt_t v);
    rlu_pkg::result_t r;
    rlu_pkg::event_e  ev;
    rlu_pkg::mode_e   m;
    logic             hit_one;
    logic             hit_two;
    logic             in_band;
    ev      = rlu_pkg::EV_NONE;
    hit_one = (v >= relay_cfg.high_one) || (v <= relay_cfg.low_one);
    hit_two = (v >= relay_cfg.high_two) || (v <= relay_cfg.low_two);
    in_band = (v < relay_cfg.high_one) && (v > relay_cfg.low_one);
    if (req == rlu_pkg::REQ_TICK) begin
      if (secs_elapsed != '1) secs_elapsed = secs_elapsed + ELAPSED_W'(1);
    end else begin
      m = prot_mode;
      case (m)
        rlu_pkg::MODE_EV1, rlu_pkg::MODE_EV2: begin
          // Level two is checked first and takes over without restarting timing.
          if (hit_two) begin
            prot_mode = rlu_pkg::MODE_EV2;
            if (secs_elapsed >= relay_cfg.delay_two) m = rlu_pkg::MODE_ALARM;
          end else if (hit_one) begin
            prot_mode = rlu_pkg::MODE_EV1;
            if (secs_elapsed >= relay_cfg.delay_one) m = rlu_pkg::MODE_ALARM;
          end else begin
            prot_mode = rlu_pkg::MODE_NORMAL;
          end
          if (m == rlu_pkg::MODE_ALARM) begin
            secs_elapsed = '0;
            prot_mode    = rlu_pkg::MODE_WAIT;
            ev           = rlu_pkg::EV_TRIP;
          end
        end
        rlu_pkg::MODE_WAIT: begin
          if (in_band) begin
            if (secs_elapsed >= relay_cfg.delay_two) begin
              prot_mode = rlu_pkg::MODE_NORMAL;
              ev        = rlu_pkg::EV_RESTORE;
            end
          end else begin
            secs_elapsed = '0;
          end
        end
        default: begin
          if (hit_one) begin
            prot_mode    = rlu_pkg::MODE_EV1;
            secs_elapsed = '0;
          end else if (hit_two) begin
            prot_mode    = rlu_pkg::MODE_EV2;
            secs_elapsed = '0;
          end
        end
      endcase
    end
    r.relay_on    = (prot_mode == rlu_pkg::MODE_NORMAL) ||
                    (prot_mode == rlu_pkg::MODE_EV1) ||
                    (prot_mode == rlu_pkg::MODE_EV2);
    r.mode        = prot_mode;
    r.alarm_event = ev;
    return r;
  endfunction

  function automatic volt_t pick_volt();
    int t;
    t = 0;
    case ($urandom_range(0, 9))
      0: t = 0;
      1: t = 4095;
      2, 3, 4, 5: begin
        case ($urandom_range(0, 3))
          0:       t = int'(relay_cfg.high_one);
          1:       t = int'(relay_cfg.low_one);
          2:       t = int'(relay_cfg.high_two);
          default: t = int'(relay_cfg.low_two);
        endcase
        t = t + int'($urandom_range(0, 2)) - 1;
      end
      6, 7: begin
        if (relay_cfg.high_one > relay_cfg.low_one + 1) begin
          t = $urandom_range(relay_cfg.low_one + 1, relay_cfg.high_one - 1);
        end else begin
          t = $urandom_range(0, 4095);
        end
      end
      default: t = $urandom_range(0, 4095);
    endcase
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return t[rlu_pkg::VOLT_W-1:0];
  endfunction

  function automatic delay_t pick_delay();
    if ($urandom_range(0, 5) == 0) return delay_t'($urandom_range(0, 3599));
    return delay_t'($urandom_range(0, 4));
  endfunction

  function automatic rlu_pkg::cfg_t phase_settings(int p);
    rlu_pkg::cfg_t c;
    int unsigned   lv[$];
    case (p)
      0: c = '{high_one: 12'd4095, low_one: 12'd0, high_two: 12'd4095, low_two: 12'd0,
               delay_one: 12'd0, delay_two: 12'd0};
      1: c = '{high_one: 12'd0, low_one: 12'd4095, high_two: 12'd0, low_two: 12'd4095,
               delay_one: 12'd0, delay_two: 12'd3599};
      default: begin
        repeat (4) lv.push_back($urandom_range(0, 4095));
        if ($urandom_range(0, 2) != 0) begin
          // Usual ordering: the level-two band sits inside the level-one band.
          lv.sort();
        end
        c.low_one   = volt_t'(lv[0]);
        c.low_two   = volt_t'(lv[1]);
        c.high_two  = volt_t'(lv[2]);
        c.high_one  = volt_t'(lv[3]);
        c.delay_one = pick_delay();
        c.delay_two = pick_delay();
      end
    endcase
    return c;
  endfunction

  function automatic step_t item_row(rlu_pkg::req_e req, int v);
    step_t s;
    s = '{is_cfg: 1'b0, req: req, val: word_t'(v), idx: '0, typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic step_t known_row(rlu_pkg::req_e req, int v, logic relay,
                                      rlu_pkg::mode_e m, rlu_pkg::event_e e);
    step_t s;
    s = item_row(req, v);
    s.typed = 1'b1;
    s.res   = '{alarm_event: e, mode: m, relay_on: relay};
    return s;
  endfunction

  function automatic step_t reg_row(idx_t idx, int v);
    step_t s;
    s = '{is_cfg: 1'b1, req: rlu_pkg::REQ_SAMPLE, val: word_t'(v), idx: idx, typed: 1'b0,
          res: '0};
    return s;
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (!no_idle) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_req(rlu_pkg::req_e req, volt_t v, bit typed, rlu_pkg::result_t res);
    rlu_pkg::result_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(rlu_pkg::IN_TDATA_W - rlu_pkg::VOLT_W){1'b0}}, v};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = relay_predict(req, v);
    results_due.push_back(typed ? res : pred);
    sent_count++;
    pace();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(idx_t idx, word_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      rlu_pkg::REG_HIGH_ONE:  relay_cfg.high_one  = val;
      rlu_pkg::REG_LOW_ONE:   relay_cfg.low_one   = val;
      rlu_pkg::REG_HIGH_TWO:  relay_cfg.high_two  = val;
      rlu_pkg::REG_LOW_TWO:   relay_cfg.low_two   = val;
      rlu_pkg::REG_DELAY_ONE: relay_cfg.delay_one = val;
      rlu_pkg::REG_DELAY_TWO: relay_cfg.delay_two = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(rlu_pkg::cfg_t c);
    wait_idle();
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
              word_t'($urandom_range(0, 4095)));
    write_reg(rlu_pkg::REG_HIGH_ONE, c.high_one);
    write_reg(rlu_pkg::REG_LOW_ONE, c.low_one);
    write_reg(rlu_pkg::REG_HIGH_TWO, c.high_two);
    write_reg(rlu_pkg::REG_LOW_TWO, c.low_two);
    write_reg(rlu_pkg::REG_DELAY_ONE, c.delay_one);
    write_reg(rlu_pkg::REG_DELAY_TWO, c.delay_two);
    cfg_we_i <= 1'b0;
  endtask

  // One excursion: a held level with ticks between samples, now and then a stray sample; else random requests.
  task automatic run_episode();
    volt_t v;
    int    n;
    v = pick_volt();
    n = $urandom_range(1, 6);
    if ($urandom_range(0, 4) == 0) begin
      repeat (n) send_req(rlu_pkg::req_e'($urandom_range(0, 1)),
                          volt_t'($urandom_range(0, 4095)), 1'b0, '0);
    end else begin
      repeat (n) begin
        send_req(rlu_pkg::REQ_SAMPLE, ($urandom_range(0, 7) == 0) ? pick_volt() : v,
                 1'b0, '0);
        repeat ($urandom_range(0, 3)) begin
          send_req(rlu_pkg::REQ_TICK, volt_t'($urandom_range(0, 4095)), 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_cycle % 7) < 3;
    endcase
  end

  always @(posedge clk_i) begin : result_check
    rlu_pkg::result_t got;
    rlu_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rlu_pkg::result_t'(m_axis_tdata[5:0]);
      if (results_due.size() == 0) begin
        if (fail_count < 10) $display("Unexpected result tdata=%h", m_axis_tdata);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (got.relay_on !== want.relay_on || got.mode !== want.mode ||
            got.alarm_event !== want.alarm_event || m_axis_tdata[7:6] !== 2'b00) begin
          if (fail_count < 10) begin
            $display("Mismatch: relay_on %b/%b mode %0d/%0d alarm_event %0d/%0d pad %b",
                     want.relay_on, got.relay_on, want.mode, got.mode,
                     want.alarm_event, got.alarm_event, m_axis_tdata[7:6]);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    step_t plan[$];
    int    start;
    relay_cfg = '{high_one: rlu_pkg::RST_HIGH_ONE, low_one: rlu_pkg::RST_LOW_ONE,
                  high_two: rlu_pkg::RST_HIGH_TWO, low_two: rlu_pkg::RST_LOW_TWO,
                  delay_one: rlu_pkg::RST_DELAY_ONE, delay_two: rlu_pkg::RST_DELAY_TWO};
    prot_mode    = rlu_pkg::MODE_NORMAL;
    secs_elapsed = '0;

    // Reset thresholds first, so the early rows also check the reset values.
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 220, 1'b1,
                             rlu_pkg::MODE_NORMAL, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 0, 1'b1,
                             rlu_pkg::MODE_EV1, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 200, 1'b1,
                             rlu_pkg::MODE_NORMAL, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 4095, 1'b1,
                             rlu_pkg::MODE_EV1, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_TICK, 4095, 1'b1,
                             rlu_pkg::MODE_EV1, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 190, 1'b1,
                             rlu_pkg::MODE_EV2, rlu_pkg::EV_NONE));
    plan.push_back(reg_row(rlu_pkg::REG_DELAY_TWO, 1));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 250, 1'b0,
                             rlu_pkg::MODE_WAIT, rlu_pkg::EV_TRIP));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 170, 1'b0,
                             rlu_pkg::MODE_WAIT, rlu_pkg::EV_NONE));
    plan.push_back(item_row(rlu_pkg::REQ_TICK, 0));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 269, 1'b1,
                             rlu_pkg::MODE_NORMAL, rlu_pkg::EV_RESTORE));
    // Level two out of reach except at the rails; level-one trip with zero delay.
    plan.push_back(reg_row(rlu_pkg::REG_HIGH_TWO, 4095));
    plan.push_back(reg_row(rlu_pkg::REG_LOW_TWO, 0));
    plan.push_back(reg_row(rlu_pkg::REG_DELAY_ONE, 0));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 300, 1'b1,
                             rlu_pkg::MODE_EV1, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 300, 1'b0,
                             rlu_pkg::MODE_WAIT, rlu_pkg::EV_TRIP));
    plan.push_back(reg_row(rlu_pkg::REG_DELAY_TWO, 0));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 270));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 171, 1'b1,
                             rlu_pkg::MODE_NORMAL, rlu_pkg::EV_RESTORE));
    plan.push_back(reg_row(REG_SPARE_A, 0));
    plan.push_back(reg_row(REG_SPARE_B, 4095));
    // Both levels hit at once from normal: level one wins.
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 0, 1'b1,
                             rlu_pkg::MODE_EV1, rlu_pkg::EV_NONE));
    plan.push_back(known_row(rlu_pkg::REQ_SAMPLE, 4095, 1'b0,
                             rlu_pkg::MODE_WAIT, rlu_pkg::EV_TRIP));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 4095));
    plan.push_back(item_row(rlu_pkg::REQ_TICK, 1234));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 220));
    // Inverted level-one limits: every sample is a level-one condition.
    plan.push_back(reg_row(rlu_pkg::REG_LOW_ONE, 4095));
    plan.push_back(reg_row(rlu_pkg::REG_HIGH_ONE, 0));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 2048));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 2048));
    plan.push_back(item_row(rlu_pkg::REQ_SAMPLE, 2048));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        write_reg(plan[i].idx, plan[i].val);
        if (i == plan.size() - 1 || !plan[i+1].is_cfg) cfg_we_i <= 1'b0;
      end else begin
        send_req(plan[i].req, plan[i].val[rlu_pkg::VOLT_W-1:0], plan[i].typed,
                 plan[i].res);
      end
    end

    // Longest delays: a long run of ticks stays well short of them, so nothing trips.
    apply_cfg('{high_one: rlu_pkg::RST_HIGH_ONE, low_one: rlu_pkg::RST_LOW_ONE,
                high_two: rlu_pkg::RST_HIGH_TWO, low_two: rlu_pkg::RST_LOW_TWO,
                delay_one: 12'd3599, delay_two: 12'd3599});
    send_req(rlu_pkg::REQ_SAMPLE, 12'd4095, 1'b0, '0);
    repeat (LONG_TICKS) begin
      send_req(rlu_pkg::REQ_TICK, volt_t'($urandom_range(0, 4095)), 1'b0, '0);
    end
    send_req(rlu_pkg::REQ_SAMPLE, 12'd4095, 1'b0, '0);
    send_req(rlu_pkg::REQ_SAMPLE, 12'd220, 1'b0, '0);
    repeat (LONG_TICKS) begin
      send_req(rlu_pkg::REQ_TICK, volt_t'($urandom_range(0, 4095)), 1'b0, '0);
    end
    send_req(rlu_pkg::REQ_SAMPLE, 12'd220, 1'b0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_cfg(phase_settings(p));
      no_idle = (p % 4 == 2);
      start   = sent_count;
      while (sent_count - start < PHASE_ITEMS) run_episode();
    end

    wait_idle();
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
